/* sv/sorted_list_insert_search_remove_core_defines.svh */
// assertion macros for the sorted list core
// used by the top level only; expects clk and rst_n in scope
`ifndef SORTED_LIST_INSERT_SEARCH_REMOVE_CORE_DEFINES_SVH
`define SORTED_LIST_INSERT_SEARCH_REMOVE_CORE_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define SLSR_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// same-cycle implication
`define SLSR_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define SLSR_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* sv/slsr_pkg.sv */
// shared types and constants of the sorted list core
// no dependencies
package slsr_pkg;

    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 7;
    localparam int COUNT_W  = 8;

    // operation codes
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_UPD
    } state_t;

    // shift command broadcast to every cell
    typedef struct packed {
        logic shift_ins;
        logic shift_rem;
    } cell_ctrl_t;

endpackage

/* sv/slsr_req_if.sv */
// request channel: opcode and value with valid/ready
// depends on slsr_pkg
interface slsr_req_if;
    logic                                valid;
    logic                                ready;
    logic        [slsr_pkg::OPCODE_W-1:0] opcode;
    logic signed [slsr_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

/* sv/slsr_rsp_if.sv */
// response channel: status, position and count with valid/ready
// depends on slsr_pkg
interface slsr_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [slsr_pkg::STATUS_W-1:0] status;
    logic [slsr_pkg::POS_W-1:0]    position;
    logic [slsr_pkg::COUNT_W-1:0]  count;

    modport source (output valid, output status, output position, output count, input ready);
    modport sink   (input valid, input status, input position, input count, output ready);
endinterface

/* sv/slsr_cell.sv */
// one slot of the sorted list: entry, compare flags and local shift logic
// depends on slsr_pkg
module slsr_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 8
) (
    input  logic                                clk,
    input  logic                                cmp_en,
    input  logic signed [slsr_pkg::VALUE_W-1:0] cmp_value,
    input  logic signed [slsr_pkg::VALUE_W-1:0] new_value,
    input  logic        [CNT_W-1:0]             count,
    input  slsr_pkg::cell_ctrl_t                ctrl,
    input  logic signed [slsr_pkg::VALUE_W-1:0] left_entry,
    input  logic signed [slsr_pkg::VALUE_W-1:0] right_entry,
    input  logic                                left_lt,
    output logic signed [slsr_pkg::VALUE_W-1:0] entry,
    output logic                                lt,
    output logic                                hit
);
    import slsr_pkg::*;

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;
    logic                      lt_reg;
    logic                      lt_next;
    logic                      eq_reg;
    logic                      eq_next;
    logic                      occupied;
    logic                      first;

    // slot holds a live entry when below the fill count
    assign occupied = CNT_W'(INDEX) < count;

    // compare against the incoming value
    always_comb
    begin
        lt_next = lt_reg;
        eq_next = eq_reg;
        if (cmp_en)
        begin
            lt_next = occupied && (entry_reg < cmp_value);
            eq_next = occupied && (entry_reg == cmp_value);
        end
    end

    // first slot not below the value: lower bound position
    assign first = !lt_reg && left_lt;
    assign hit   = first && eq_reg;

    // shift: slots below the lower bound hold, others move one place
    always_comb
    begin
        entry_next = entry_reg;
        if (!lt_reg)
        begin
            if (ctrl.shift_ins)
            begin
                entry_next = first ? new_value : left_entry;
            end
            else if (ctrl.shift_rem)
            begin
                entry_next = right_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        lt_reg    <= lt_next;
        eq_reg    <= eq_next;
    end

    assign entry = entry_reg;
    assign lt    = lt_reg;

endmodule

/* sv/slsr_pos_enc.sv */
// thermometer-to-binary encoder for the row of less-than flags
// no dependencies
module slsr_pos_enc #(
    parameter int N  = 128,
    parameter int PW = 8
) (
    input  logic [N-1:0]  therm,
    output logic [PW-1:0] pos
);
    localparam int PN = 2 ** PW;

    logic [PN-1:0] padded;
    logic [PW-1:0] pos_v;
    logic [PW-1:0] idx;

    assign padded = PN'(therm);

    // binary search on the boundary, one bit per step
    always_comb
    begin
        pos_v = '0;
        idx   = '0;
        for (int b = PW - 1; b >= 0; b--)
        begin
            idx = pos_v | PW'((1 << b) - 1);
            if (padded[idx])
            begin
                pos_v = pos_v | PW'(1 << b);
            end
        end
    end

    assign pos = pos_v;

endmodule

/* sv/sorted_list_insert_search_remove_core.sv */
// Sorted list core: keeps up to CAPACITY signed 32-bit values in ascending
// order in a row of cells, each holding one entry.
// Request channel (req): opcode and value; insert, search or remove.
// Response channel (rsp): status, position and count, one per request.
// A request is taken when req.valid and req.ready are high at a clock edge.
// In that cycle every cell compares its entry with the value and registers
// the flags; once the output register is free, the cells shift by one place
// toward or away from the lower bound for a successful insert or remove, and
// the result is loaded into the output register. The core does not take a
// new request until that result is loaded: req.ready is high only while idle.
// A result waiting in the output register does not block the next request:
// its compare runs, and only its shift cycle waits until rsp.ready frees
// the output register.
// Reset empties the list (count zero), returns to idle and clears rsp.valid; entry
// contents are left as they are and never read before being written.
// depends on slsr_pkg, slsr_req_if, slsr_rsp_if, slsr_cell, slsr_pos_enc
`include "sorted_list_insert_search_remove_core_defines.svh"

module sorted_list_insert_search_remove_core #(
    parameter int CAPACITY = 128
) (
    input logic          clk,
    input logic          rst_n,
    slsr_req_if.sink     req,
    slsr_rsp_if.source   rsp
);
    import slsr_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t                    state_reg;
    state_t                    state_next;
    logic [OPCODE_W-1:0]       op_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;

    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    status_t                   rsp_status_reg;
    status_t                   status_next;
    logic [POS_W-1:0]          rsp_pos_reg;
    logic [POS_W-1:0]          pos_next;
    logic [COUNT_W-1:0]        rsp_count_reg;

    logic                      accept;
    logic                      done;
    logic                      full;
    logic                      empty;
    logic                      found;
    logic                      lt_ordered;
    logic [CNT_W-1:0]          lb_pos;
    cell_ctrl_t                ctrl;

    logic signed [VALUE_W-1:0] entry_arr [CAPACITY];
    logic [CAPACITY-1:0]       lt_vec;
    logic [CAPACITY-1:0]       hit_vec;

    // handshake
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign done      = (state_reg == S_UPD) && (!rsp_valid_reg || rsp.ready);

    // row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_e;
        logic signed [VALUE_W-1:0] right_e;
        logic                      left_l;

        if (i == 0)
        begin : g_head
            assign left_e = value_reg;
            assign left_l = 1'b1;
        end
        else
        begin : g_body
            assign left_e = entry_arr[i-1];
            assign left_l = lt_vec[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_e = entry_arr[i];
        end
        else
        begin : g_inner
            assign right_e = entry_arr[i+1];
        end

        slsr_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .cmp_en      (accept),
            .cmp_value   (req.value),
            .new_value   (value_reg),
            .count       (count_reg),
            .ctrl        (ctrl),
            .left_entry  (left_e),
            .right_entry (right_e),
            .left_lt     (left_l),
            .entry       (entry_arr[i]),
            .lt          (lt_vec[i]),
            .hit         (hit_vec[i])
        );
    end

    // lower bound from the less-than flags
    slsr_pos_enc #(
        .N  (CAPACITY),
        .PW (CNT_W)
    ) u_pos_enc (
        .therm (lt_vec),
        .pos   (lb_pos)
    );

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);
    assign found = |hit_vec;

    // operation outcome and shift command
    always_comb
    begin
        status_next    = ST_OK;
        pos_next       = '0;
        count_next     = count_reg;
        ctrl.shift_ins = 1'b0;
        ctrl.shift_rem = 1'b0;
        unique case (op_reg)
            OP_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    pos_next       = POS_W'(lb_pos);
                    ctrl.shift_ins = done;
                    if (done)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            OP_SEARCH, OP_REMOVE:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!found)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else
                begin
                    pos_next = POS_W'(lb_pos);
                    if (op_reg == OP_REMOVE)
                    begin
                        ctrl.shift_rem = done;
                        if (done)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (done)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= req.opcode;
            value_reg <= req.value;
        end
        if (done)
        begin
            rsp_status_reg <= status_next;
            rsp_pos_reg    <= pos_next;
            rsp_count_reg  <= COUNT_W'(count_next);
        end
    end

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.status   = rsp_status_reg;
    assign rsp.position = rsp_pos_reg;
    assign rsp.count    = rsp_count_reg;

    // less-than flags form a run of ones from cell zero
    assign lt_ordered = (((lt_vec >> 1) & ~lt_vec) == '0);

    // checks
    `SLSR_ASSERT(a_count_bound, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `SLSR_ASSERT_IMP(a_sorted_flags, state_reg == S_UPD, lt_ordered, "flags out of order")
    `SLSR_ASSERT_IMP(a_single_hit, state_reg == S_UPD, $onehot0(hit_vec), "several cells hit")
    `SLSR_ASSERT_NEXT(a_count_hold, !done, $stable(count_reg), "count changed outside update")
    `SLSR_ASSERT_NEXT(a_result_loaded, done, rsp_valid_reg, "update cycle produced no result")

endmodule

/* tb/testbench.sv */
// self-checking testbench for the sorted list core: directed and random
// insert, search and remove transactions, each reply checked against a mirror
// depends on slsr_pkg, slsr_req_if, slsr_rsp_if and the core
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import slsr_pkg::*;

    localparam int LIST_DEPTH  = 128;
    localparam int NUM_ITEMS   = 1000;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_REPORTS = 10;

    // opcode 3 is not an operation, the core answers it without a change
    localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        status_t              status;
        logic [POS_W-1:0]     position;
        logic [COUNT_W-1:0]   count;
    } reply_t;

    // mirror of the list contents plus the replies still owed by the core
    class sorted_list_mirror;
        logic signed [VALUE_W-1:0] entries [LIST_DEPTH];
        int                        fill;
        reply_t                    pending_replies [$];
        int                        failures;

        function new();
            fill     = 0;
            failures = 0;
        endfunction

        // first slot whose entry is not smaller than the value
        function int lower_bound(logic signed [VALUE_W-1:0] val);
            int idx;
            idx = 0;
            while (idx < fill && entries[idx] < val)
                idx++;
            return idx;
        endfunction

        // apply one operation to the mirror and work out its reply
        function reply_t apply_op(logic [OPCODE_W-1:0] op, logic signed [VALUE_W-1:0] val);
            reply_t r;
            int     slot;
            r.status   = ST_OK;
            r.position = '0;
            case (op)
                OP_INSERT:
                begin
                    if (fill >= LIST_DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        slot = lower_bound(val);
                        for (int j = fill; j > slot; j--)
                            entries[j] = entries[j-1];
                        entries[slot] = val;
                        fill++;
                        r.position = slot[POS_W-1:0];
                    end
                end
                OP_SEARCH, OP_REMOVE:
                begin
                    if (fill == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        slot = lower_bound(val);
                        if (slot >= fill || entries[slot] != val)
                            r.status = ST_NOT_FOUND;
                        else
                        begin
                            r.position = slot[POS_W-1:0];
                            if (op == OP_REMOVE)
                            begin
                                for (int j = slot; j + 1 < fill; j++)
                                    entries[j] = entries[j+1];
                                fill--;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
            r.count = fill[COUNT_W-1:0];
            return r;
        endfunction

        function void note_request(logic [OPCODE_W-1:0] op, logic signed [VALUE_W-1:0] val);
            pending_replies.push_back(apply_op(op, val));
        endfunction

        function void check_reply(logic [STATUS_W-1:0] st, logic [POS_W-1:0] pos,
                                  logic [COUNT_W-1:0] cnt);
            reply_t want;
            if (pending_replies.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected response transaction: status %0d position %0d count %0d",
                             st, pos, cnt);
                return;
            end
            want = pending_replies.pop_front();
            if (st !== want.status || pos !== want.position || cnt !== want.count)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("response mismatch: expected status %0d position %0d count %0d, %s",
                             want.status, want.position, want.count,
                             $sformatf("got status %0d position %0d count %0d", st, pos, cnt));
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    bit                hold_request = 1'b0;
    int                cycle_count = 0;
    sorted_list_mirror list_mirror = new();

    slsr_req_if req_ch ();
    slsr_rsp_if rsp_ch ();

    sorted_list_insert_search_remove_core #(
        .CAPACITY (LIST_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    // check every accepted response transaction
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            list_mirror.check_reply(rsp_ch.status, rsp_ch.position, rsp_ch.count);
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // value that often hits an entry already in the list
    function automatic logic signed [VALUE_W-1:0] pick_value(int hit_pct);
        int                        r;
        logic signed [VALUE_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < hit_pct && list_mirror.fill > 0)
            return list_mirror.entries[$urandom_range(0, list_mirror.fill - 1)];
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            v = $urandom_range(0, 15);
            return v - 32'sd8;
        end
        if (r < 45)
        begin
            case ($urandom_range(0, 5))
                0: v = VAL_MIN;
                1: v = VAL_MAX;
                2: v = VAL_MIN + 32'sd1;
                3: v = VAL_MAX - 32'sd1;
                4: v = 32'sd0;
                default: v = -32'sd1;
            endcase
            return v;
        end
        v = $urandom;
        return v;
    endfunction

    function automatic logic [OPCODE_W-1:0] pick_op(int ins_pct, int rem_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            return OP_INSERT;
        if (r < ins_pct + rem_pct)
            return OP_REMOVE;
        if (r < 97)
            return OP_SEARCH;
        return OP_NOP;
    endfunction

    // offer one request transaction and wait until the core takes it
    task automatic send_request(input logic [OPCODE_W-1:0] op,
                                input logic signed [VALUE_W-1:0] val);
        req_ch.valid  <= 1'b1;
        req_ch.opcode <= op;
        req_ch.value  <= val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        list_mirror.note_request(op, val);
    endtask

    task automatic pause_sender(input int n);
        if (n > 0)
        begin
            req_ch.valid  <= 1'b0;
            req_ch.opcode <= $urandom;
            req_ch.value  <= $urandom;
            repeat (n) @(posedge clk);
        end
    endtask

    // response side: random ready with one long hold-off on request
    initial
    begin
        int held;
        rsp_ch.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                rsp_ch.ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    held++;
                end
                hold_request = 1'b0;
            end
            else if ($urandom_range(0, 99) < 55)
            begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b0;
                repeat (idle_length() + 1) @(posedge clk);
            end
        end
    end

    // request side: reset, directed cases, random phases, drain
    initial
    begin
        int                   sent;
        int                   phase_len;
        int                   ins_pct;
        int                   rem_pct;
        int                   no_idle_left;
        bit                   phase_no_idle;
        bit                   hold_done;
        logic [OPCODE_W-1:0]  op;

        req_ch.valid  = 1'b0;
        req_ch.opcode = OP_INSERT;
        req_ch.value  = '0;
        sent          = 0;
        no_idle_left  = 0;
        hold_done     = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, no-op, extremes, duplicates and misses
        send_request(OP_SEARCH, 32'sd0);
        send_request(OP_REMOVE, 32'sd5);
        send_request(OP_NOP, -32'sd1);
        send_request(OP_INSERT, 32'sd0);
        send_request(OP_INSERT, VAL_MAX);
        send_request(OP_INSERT, VAL_MIN);
        send_request(OP_INSERT, -32'sd1);
        send_request(OP_INSERT, 32'sd0);
        send_request(OP_SEARCH, 32'sd0);
        send_request(OP_SEARCH, VAL_MIN);
        send_request(OP_SEARCH, VAL_MAX);
        send_request(OP_SEARCH, 32'sd12345);
        send_request(OP_SEARCH, VAL_MAX - 32'sd1);
        send_request(OP_REMOVE, 32'sd0);
        send_request(OP_REMOVE, 32'sd0);
        send_request(OP_REMOVE, 32'sd0);
        send_request(OP_REMOVE, VAL_MAX);
        send_request(OP_NOP, 32'sd0);
        send_request(OP_INSERT, 32'sd1);
        send_request(OP_INSERT, 32'sd1);
        send_request(OP_REMOVE, -32'sd1);
        send_request(OP_REMOVE, VAL_MIN);
        send_request(OP_REMOVE, 32'sd1);
        send_request(OP_REMOVE, 32'sd1);
        send_request(OP_REMOVE, 32'sd1);

        // random phases: fill to capacity, drain to empty, then a mix
        while (sent < NUM_ITEMS)
        begin
            if (sent == 0)
            begin
                phase_len = 250;
                ins_pct   = 80;
                rem_pct   = 7;
            end
            else if (sent == 250)
            begin
                phase_len = 300;
                ins_pct   = 5;
                rem_pct   = 85;
            end
            else
            begin
                phase_len = $urandom_range(60, 180);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        ins_pct = 75;
                        rem_pct = 10;
                    end
                    1:
                    begin
                        ins_pct = 15;
                        rem_pct = 70;
                    end
                    default:
                    begin
                        ins_pct = 40;
                        rem_pct = 35;
                    end
                endcase
            end
            phase_no_idle = ($urandom_range(0, 3) == 0);

            for (int k = 0; k < phase_len && sent < NUM_ITEMS; k++)
            begin
                // long receiver hold-off while requests keep coming
                if (!hold_done && sent >= 400)
                begin
                    hold_request = 1'b1;
                    hold_done    = 1'b1;
                    no_idle_left = 80;
                end
                op = pick_op(ins_pct, rem_pct);
                send_request(op, pick_value(op == OP_INSERT ? 30 : 60));
                sent++;
                if (no_idle_left > 0)
                    no_idle_left--;
                else if (!phase_no_idle)
                    pause_sender(idle_length());
            end
        end

        // wait for all replies, then keep watching for stray replies
        req_ch.valid <= 1'b0;
        while (list_mirror.pending_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (list_mirror.failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/slsr_pkg.sv
sv/slsr_req_if.sv
sv/slsr_rsp_if.sv
sv/slsr_cell.sv
sv/slsr_pos_enc.sv
sv/sorted_list_insert_search_remove_core.sv
tb/testbench.sv
